FILE: rtl/pfsge_pkg.sv
// shared types, codes and truth tables of the packed four-state gate evaluator
// no dependencies

package pfsge_pkg;

   localparam int unsigned SIGNAL_COUNT_DEFAULT = 1024;
   localparam int unsigned IDX_W                = 10;
   localparam int unsigned TRAY_W               = 6;
   localparam int unsigned TRAY_SHIFT           = 5;
   localparam logic [TRAY_W-1:0] ACTIVE_TRAYS_RESET = 6'd32;

   localparam logic [1:0] CMD_EVAL  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [3:0] GATE_AND  = 4'd0;
   localparam logic [3:0] GATE_OR   = 4'd1;
   localparam logic [3:0] GATE_XOR  = 4'd2;
   localparam logic [3:0] GATE_NOT  = 4'd3;
   localparam logic [3:0] GATE_NAND = 4'd4;
   localparam logic [3:0] GATE_NOR  = 4'd5;
   localparam logic [3:0] GATE_XNOR = 4'd6;
   localparam logic [3:0] GATE_BUF  = 4'd7;
   localparam logic [3:0] GATE_TRI  = 4'd8;
   localparam logic [3:0] GATE_VCC  = 4'd9;
   localparam logic [3:0] GATE_GND  = 4'd10;
   localparam logic [3:0] GATE_PUP  = 4'd11;
   localparam logic [3:0] GATE_PDN  = 4'd12;

   localparam logic [1:0] SIG_ZERO = 2'd0;
   localparam logic [1:0] SIG_ONE  = 2'd1;

   localparam logic [1:0] TT_AND [0:15] = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3,
                                            2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3};
   localparam logic [1:0] TT_OR [0:15]  = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
                                            2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3};
   localparam logic [1:0] TT_XOR [0:15] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                            2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd2};
   localparam logic [1:0] TT_NAND [0:15] = '{2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                             2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd2};
   localparam logic [1:0] TT_NOR [0:15] = '{2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
                                            2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2};
   localparam logic [1:0] TT_XNOR [0:15] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3,
                                             2'd3, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3};
   localparam logic [1:0] TT_TRI [0:15] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1,
                                            2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd3, 2'd0, 2'd3};
   localparam logic [1:0] TT_NOT [0:3] = '{2'd1, 2'd0, 2'd3, 2'd2};
   localparam logic [1:0] TT_PUP [0:3] = '{2'd1, 2'd1, 2'd3, 2'd3};
   localparam logic [1:0] TT_PDN [0:3] = '{2'd0, 2'd0, 2'd2, 2'd2};

   typedef struct packed {
      logic [1:0]       cmd;
      logic [3:0]       gate;
      logic [IDX_W-1:0] src_a;
      logic [IDX_W-1:0] src_b;
      logic [IDX_W-1:0] dst;
      logic [1:0]       value;
   } req_type;

   typedef struct packed {
      logic [1:0] result_value;
      logic       changed;
   } rsp_type;

   typedef struct packed {
      logic       known;
      logic [1:0] value;
   } gate_out_type;

   function automatic gate_out_type gate_lookup(input logic [3:0] gate, input logic [1:0] a,
                                                input logic [1:0] b);
      gate_out_type r;
      logic [3:0]   ix;
      ix      = {a, b};
      r.known = 1'b1;
      r.value = SIG_ZERO;
      case (gate)
         GATE_AND:  r.value = TT_AND[ix];
         GATE_OR:   r.value = TT_OR[ix];
         GATE_XOR:  r.value = TT_XOR[ix];
         GATE_NOT:  r.value = TT_NOT[a];
         GATE_NAND: r.value = TT_NAND[ix];
         GATE_NOR:  r.value = TT_NOR[ix];
         GATE_XNOR: r.value = TT_XNOR[ix];
         GATE_BUF:  r.value = a;
         GATE_TRI:  r.value = TT_TRI[ix];
         GATE_VCC:  r.value = SIG_ONE;
         GATE_GND:  r.value = SIG_ZERO;
         GATE_PUP:  r.value = TT_PUP[a];
         GATE_PDN:  r.value = TT_PDN[a];
         default:   r.known = 1'b0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/packed_four_state_gate_evaluator.sv
// one request at a time: after accept it passes evaluate, then commit, which registers
//   the response and waits while the last one is held; it runs the read, evaluate,
//   write-back sequence on the signal ram (source reads, then destination read and
//   write); reset: synchronous, active high; afterwards a clearing pass zeroes the
//   signal ram, with req_ready low; csr writes are taken whenever reset is low
// depends on pfsge_pkg and pfsge_ram

module packed_four_state_gate_evaluator #(
   parameter int unsigned SIGNAL_COUNT = pfsge_pkg::SIGNAL_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pfsge_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pfsge_pkg::rsp_type                  rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfsge_pkg::TRAY_W-1:0]        csr_data
);

   import pfsge_pkg::*;

   localparam int unsigned AW    = $clog2(SIGNAL_COUNT);
   localparam int unsigned ACT_W = TRAY_W + TRAY_SHIFT;
   localparam logic [AW-1:0] LAST_ADDR = AW'(SIGNAL_COUNT - 1);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_EVAL   = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clear_cnt_ff, clear_cnt_in;
   logic [TRAY_W-1:0] active_trays_ff, active_trays_in;
   req_type           item_ff, item_in;
   logic [1:0]        res_ff, res_in;
   logic              wr_ff, wr_in;
   logic              rd_sel_ff, rd_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic              req_fire;
   logic              out_free;
   logic              commit_fire;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [1:0]        ram_wdata;
   logic [AW-1:0]     ram_raddr_a;
   logic [AW-1:0]     ram_raddr_b;
   logic [1:0]        ram_rdata_a;
   logic [1:0]        ram_rdata_b;
   logic              a_in_range;
   logic              b_in_range;
   logic              dst_in_range;
   logic              dst_active;
   logic [1:0]        src_a_val;
   logic [1:0]        src_b_val;
   gate_out_type      gate_out;

   pfsge_ram #(
      .WIDTH (2),
      .DEPTH (SIGNAL_COUNT)
   ) u_signal_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (ram_rdata_b)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign commit_fire = (state_ff == S_COMMIT) && out_free;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;

   assign a_in_range   = (32'(item_ff.src_a) < SIGNAL_COUNT);
   assign b_in_range   = (32'(item_ff.src_b) < SIGNAL_COUNT);
   assign dst_in_range = (32'(item_ff.dst) < SIGNAL_COUNT);
   assign dst_active   = (ACT_W'(item_ff.dst) < {active_trays_ff, {TRAY_SHIFT{1'b0}}});
   assign src_a_val    = a_in_range ? ram_rdata_a : SIG_ZERO;
   assign src_b_val    = b_in_range ? ram_rdata_b : SIG_ZERO;
   assign gate_out     = gate_lookup(item_ff.gate, src_a_val, src_b_val);

   // source reads at accept, destination read during evaluate and commit
   always_comb begin
      if (state_ff == S_IDLE) begin
         ram_raddr_a = AW'(req_item.src_a);
         ram_raddr_b = AW'(req_item.src_b);
      end else if (state_ff == S_EVAL || state_ff == S_COMMIT) begin
         ram_raddr_a = AW'(item_ff.dst);
         ram_raddr_b = AW'(item_ff.src_b);
      end else begin
         ram_raddr_a = clear_cnt_ff;
         ram_raddr_b = clear_cnt_ff;
      end
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clear_cnt_ff;
         ram_wdata = SIG_ZERO;
      end else begin
         ram_we    = commit_fire && wr_ff;
         ram_waddr = AW'(item_ff.dst);
         ram_wdata = res_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      clear_cnt_in    = clear_cnt_ff;
      active_trays_in = csr_valid ? csr_data : active_trays_ff;
      item_in         = req_fire ? req_item : item_ff;
      res_in          = res_ff;
      wr_in           = wr_ff;
      rd_sel_in       = rd_sel_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_item_in     = rsp_item_ff;
      case (state_ff)
         S_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_in    = SIG_ZERO;
            wr_in     = 1'b0;
            rd_sel_in = 1'b0;
            case (item_ff.cmd)
               CMD_EVAL: begin
                  res_in = gate_out.known ? gate_out.value : SIG_ZERO;
                  wr_in  = gate_out.known && dst_in_range;
               end
               CMD_WRITE: begin
                  wr_in  = dst_active && dst_in_range;
                  res_in = (dst_active && dst_in_range) ? item_ff.value : SIG_ZERO;
               end
               CMD_READ: begin
                  rd_sel_in = dst_active && dst_in_range;
               end
               default: begin
                  res_in = SIG_ZERO;
               end
            endcase
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.result_value = rd_sel_ff ? ram_rdata_a : res_ff;
               rsp_item_in.changed      = wr_ff && (ram_rdata_a != res_ff);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clear_cnt_ff    <= '0;
         active_trays_ff <= ACTIVE_TRAYS_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_cnt_ff    <= clear_cnt_in;
         active_trays_ff <= active_trays_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      item_ff     <= item_in;
      res_ff      <= res_in;
      wr_ff       <= wr_in;
      rd_sel_ff   <= rd_sel_in;
      rsp_item_ff <= rsp_item_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_COMMIT))
      else $error("signal ram written outside clear or commit");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_COMMIT))
      else $error("response raised without a commit");

   assert property (@(posedge clock) disable iff (reset)
      commit_fire |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("commit did not load the response register");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && !out_free) |=> (state_ff == S_COMMIT && $stable(item_ff)))
      else $error("stalled commit lost its transaction");

endmodule

FILE: rtl/pfsge_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies

module pfsge_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
